/* rtl/double_integer_fraction_split_top_assert.svh */
// Assertion macros for the fraction split block
`ifndef DOUBLE_INTEGER_FRACTION_SPLIT_TOP_ASSERT_SVH
`define DOUBLE_INTEGER_FRACTION_SPLIT_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the trigger
`define DIFS_ASSERT_IMP(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the trigger
`define DIFS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/difs_pkg.sv */
package difs_pkg;

    localparam int unsigned MantW = 52;
    localparam int unsigned ExpW  = 11;
    localparam int unsigned PosW  = 6;

    localparam logic [ExpW-1:0] ExpOne     = 11'h3ff;
    localparam logic [ExpW-1:0] ExpAllInt  = 11'h433;
    localparam logic [ExpW-1:0] ExpSpecial = 11'h7ff;

    typedef enum logic [1:0] {
        t_CASE_BIG   = 2'd0,
        t_CASE_SMALL = 2'd1,
        t_CASE_MID   = 2'd2,
        t_CASE_NAN   = 2'd3
    } t_case;

    // stage 1 to stage 2
    typedef struct packed {
        logic [63:0]     x;
        t_case           kind;
        logic [MantW-1:0] m;
    } t_s1;

    // stage 2 to stage 3
    typedef struct packed {
        logic [63:0]     x;
        t_case           kind;
        logic [MantW-1:0] m;
        logic [PosW-1:0] lz;
        logic            zero;
    } t_s2;

endpackage

/* rtl/double_integer_fraction_split_top.sv */
// Splits a binary64 pattern into integral and fractional parts, both with the
// sign of x. Three register stages (classify and mask, leading-zero count,
// normalise and select); one item is taken every cycle unless o_stall is
// high. A stall freezes the whole pipeline, and an empty output register lets
// the next item move on, so throughput is one item per cycle when the sink
// never stalls. NaNs, including signalling ones, pass through unchanged.
`include "double_integer_fraction_split_top_assert.svh"

module double_integer_fraction_split_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_int_part,
    output logic [63:0] o_frac_part
);
    import difs_pkg::*;

    logic w_en;
    logic w_v1;
    logic w_v2;
    t_s1  w_s1;
    t_s2  w_s2;

    // advance when the output register is free or being taken
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    difs_classify u_cls (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_x_bits),
        .o_valid (w_v1),
        .o_s1    (w_s1)
    );

    difs_lzc u_lzc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_s1    (w_s1),
        .o_valid (w_v2),
        .o_s2    (w_s2)
    );

    difs_assemble u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v2),
        .i_s2    (w_s2),
        .o_valid (o_valid),
        .o_int   (o_int_part),
        .o_frac  (o_frac_part)
    );

    // a held result keeps its payload
    `DIFS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_int_part) && $stable(o_frac_part))
    // stall to the source only while the output is full and held
    `DIFS_ASSERT_IMP(a_stall, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // both parts carry the sign of x
    `DIFS_ASSERT_IMP(a_sign, i_clk, i_rst_n, o_valid,
        o_int_part[63] == o_frac_part[63])
endmodule

/* rtl/difs_classify.sv */
module difs_classify (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_x,
    output logic           o_valid,
    output difs_pkg::t_s1  o_s1
);
    import difs_pkg::*;

    logic [ExpW-1:0]  w_e;
    logic [5:0]       w_nfrac;
    logic [MantW-1:0] w_low;
    t_s1              n_s1;
    t_s1              r_s1;
    logic             r_valid;

    assign w_e = i_x[62:52];

    always_comb begin
        w_nfrac = 6'(ExpAllInt - w_e);
        w_low   = (52'd1 << w_nfrac) - 52'd1;
        if (w_nfrac == 6'd52) begin
            w_low = '1;
        end
        n_s1.x = i_x;
        n_s1.m = i_x[51:0] & w_low;
        if (w_e == ExpSpecial && i_x[51:0] != '0) begin
            n_s1.kind = t_CASE_NAN;
        end else if (w_e >= ExpAllInt) begin
            n_s1.kind = t_CASE_BIG;
        end else if (w_e < ExpOne) begin
            n_s1.kind = t_CASE_SMALL;
        end else begin
            n_s1.kind = t_CASE_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;
endmodule

/* rtl/difs_lzc.sv */
module difs_lzc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  difs_pkg::t_s1  i_s1,
    output logic           o_valid,
    output difs_pkg::t_s2  o_s2
);
    import difs_pkg::*;

    logic [PosW-1:0] w_lz;
    t_s2             r_s2;
    logic            r_valid;

    // leading zeros of the 52-bit remainder
    always_comb begin
        w_lz = '0;
        for (int i = 0; i < MantW; i++) begin
            if (i_s1.m[i]) begin
                w_lz = PosW'(MantW - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2.x    <= i_s1.x;
            r_s2.kind <= i_s1.kind;
            r_s2.m    <= i_s1.m;
            r_s2.lz   <= w_lz;
            r_s2.zero <= (i_s1.m == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;
endmodule

/* rtl/difs_assemble.sv */
module difs_assemble (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  difs_pkg::t_s2  i_s2,
    output logic           o_valid,
    output logic [63:0]    o_int,
    output logic [63:0]    o_frac
);
    import difs_pkg::*;

    logic             w_sign;
    logic [ExpW-1:0]  w_e;
    logic [5:0]       w_nfrac;
    logic [MantW-1:0] w_low;
    logic [MantW-1:0] w_sh;
    logic [ExpW-1:0]  w_be;
    logic [63:0]      n_int;
    logic [63:0]      n_frac;
    logic [63:0]      r_int;
    logic [63:0]      r_frac;
    logic             r_valid;

    always_comb begin
        w_sign  = i_s2.x[63];
        w_e     = i_s2.x[62:52];
        w_nfrac = 6'(ExpAllInt - w_e);
        w_low   = (52'd1 << w_nfrac) - 52'd1;
        if (w_nfrac == 6'd52) begin
            w_low = '1;
        end
        // shift past the leading one; it becomes the hidden bit
        w_sh = (i_s2.m << i_s2.lz) << 1;
        // p = 51 - lz, exponent = p + e - 52
        w_be = w_e - ExpW'(i_s2.lz) - 11'd1;
        n_int  = i_s2.x;
        n_frac = i_s2.x;
        case (i_s2.kind)
            t_CASE_NAN: begin
                n_int  = i_s2.x;
                n_frac = i_s2.x;
            end
            t_CASE_BIG: begin
                n_int  = i_s2.x;
                n_frac = {w_sign, 63'd0};
            end
            t_CASE_SMALL: begin
                n_int  = {w_sign, 63'd0};
                n_frac = i_s2.x;
            end
            t_CASE_MID: begin
                n_int = {i_s2.x[63:52], i_s2.x[51:0] & ~w_low};
                if (i_s2.zero) begin
                    n_frac = {w_sign, 63'd0};
                end else begin
                    n_frac = {w_sign, w_be, w_sh};
                end
            end
            default: begin
                n_int  = i_s2.x;
                n_frac = i_s2.x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_int  <= n_int;
            r_frac <= n_frac;
        end
    end

    assign o_valid = r_valid;
    assign o_int   = r_int;
    assign o_frac  = r_frac;
endmodule
